@@ hdl/boll_pkg.sv @@
`default_nettype none
package boll_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int COUNT_W    = 5;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RM_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RM_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RM_MATCH  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic ins_front;
      logic ins_back;
      logic rm_front;
      logic rm_back;
      logic rm_match;
   } boll_ctl_type;

endpackage
`default_nettype wire

@@ hdl/boll_cell.sv @@
`default_nettype none
module boll_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire boll_pkg::boll_ctl_type       ctl,
   input  wire logic [boll_pkg::DATA_W-1:0]  item_value,
   input  wire logic [boll_pkg::DATA_W-1:0]  left_value,
   input  wire logic                         left_valid,
   input  wire logic [boll_pkg::DATA_W-1:0]  right_value,
   input  wire logic                         right_valid,
   input  wire logic                         found_in,
   output logic      [boll_pkg::DATA_W-1:0]  value,
   output logic                              valid,
   output logic                              found_out,
   output logic                              hit,
   output logic                              last
);
   import boll_pkg::*;

   logic [DATA_W-1:0] value_ff, value_in;
   logic              valid_ff, valid_in;
   logic              match;
   logic              take_right;

   assign match      = valid_ff && (value_ff == item_value);
   assign hit        = match && !found_in;
   assign found_out  = found_in || match;
   assign last       = valid_ff && !right_valid;
   assign take_right = ctl.rm_front || (ctl.rm_back && last) || (ctl.rm_match && found_out);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.ins_front) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (ctl.ins_back && !valid_ff && left_valid) begin
         value_in = item_value;
         valid_in = 1'b1;
      end else if (take_right) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
endmodule
`default_nettype wire

@@ hdl/bounded_ordered_list_engine.sv @@
`default_nettype none
// Ordered list of up to LIST_DEPTH signed 32-bit values held in a row of cells, front at
// cell 0. One command is taken per cycle; its result is registered and shows on the rsp_
// channel the cycle after the transfer, and the next command is taken in that same cycle
// when the result is taken or the output register is empty. The cycle is set by the cell
// row: every cell compares its entry with the command value and a first-match flag ripples
// from the front through all cells, steering which cells shift toward the front.
module bounded_ordered_list_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [boll_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic signed [boll_pkg::DATA_W-1:0] req_item_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [boll_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [boll_pkg::POS_W-1:0]     rsp_match_position,
   output logic      [boll_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic signed [boll_pkg::DATA_W-1:0]  rsp_total
);
   import boll_pkg::*;

   logic [DATA_W-1:0]   cell_value [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] cell_valid, cell_hit, cell_last;
   logic [LIST_DEPTH:0] found_chain;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]   total_ff, total_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                fire, empty, full, found;
   logic                do_ins, do_rm;
   logic [DATA_W-1:0]   removed, last_value, hit_value;
   logic [POS_W-1:0]    hit_pos;
   boll_ctl_type        ctl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(LIST_DEPTH));
   assign found     = found_chain[LIST_DEPTH];
   assign found_chain[0] = 1'b0;

   always_comb begin
      status_in = ST_OK;
      pos_in    = '0;
      ctl       = '0;
      case (req_cmd)
         CMD_INS_FRONT: begin
            if (full) status_in = ST_FULL;
            else ctl.ins_front = fire;
         end
         CMD_INS_BACK: begin
            if (full) status_in = ST_FULL;
            else ctl.ins_back = fire;
         end
         CMD_RM_FRONT: begin
            if (empty) status_in = ST_EMPTY;
            else ctl.rm_front = fire;
         end
         CMD_RM_BACK: begin
            if (empty) status_in = ST_EMPTY;
            else ctl.rm_back = fire;
         end
         CMD_RM_MATCH: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               ctl.rm_match = fire;
               pos_in       = hit_pos;
            end
         end
         CMD_SEARCH: begin
            if (!found) status_in = ST_NOT_FOUND;
            else pos_in = hit_pos;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      hit_pos    = '0;
      hit_value  = '0;
      last_value = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (cell_hit[i]) begin
            hit_pos   = hit_pos | POS_W'(i);
            hit_value = hit_value | cell_value[i];
         end
         if (cell_last[i]) last_value = last_value | cell_value[i];
      end
   end

   assign do_ins  = ctl.ins_front || ctl.ins_back;
   assign do_rm   = ctl.rm_front || ctl.rm_back || ctl.rm_match;
   assign removed = ctl.rm_front ? cell_value[0] : (ctl.rm_back ? last_value : hit_value);

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
         total_in = total_ff + DATA_W'(req_item_value);
      end else if (do_rm) begin
         count_in = count_ff - CNT_W'(1);
         total_in = total_ff - removed;
      end
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      boll_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .item_value  (DATA_W'(req_item_value)),
         .left_value  ((g == 0) ? DATA_W'(req_item_value) : cell_value[(g == 0) ? 0 : g - 1]),
         .left_valid  ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g - 1]),
         .right_value ((g == LIST_DEPTH - 1) ? '0
                       : cell_value[(g == LIST_DEPTH - 1) ? g : g + 1]),
         .right_valid ((g == LIST_DEPTH - 1) ? 1'b0
                       : cell_valid[(g == LIST_DEPTH - 1) ? g : g + 1]),
         .found_in    (found_chain[g]),
         .value       (cell_value[g]),
         .valid       (cell_valid[g]),
         .found_out   (found_chain[g+1]),
         .hit         (cell_hit[g]),
         .last        (cell_last[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         status_ff <= status_in;
         pos_ff    <= pos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_match_position = pos_ff;
   assign rsp_entry_count    = COUNT_W'(count_ff);
   assign rsp_total          = total_ff;
endmodule
`default_nettype wire

@@ hdl/boll_checker.sv @@
`default_nettype none
module boll_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [boll_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [boll_pkg::POS_W-1:0]     rsp_match_position,
   input wire logic [boll_pkg::COUNT_W-1:0]   rsp_entry_count,
   input wire logic signed [boll_pkg::DATA_W-1:0] rsp_total
);
   import boll_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == COUNT_W'(LIST_DEPTH))
      else $error("full status with count below depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0 && rsp_total == '0)
      else $error("empty status with entries or nonzero total");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_match_position == '0)
      else $error("match position set on failed command");
endmodule

bind bounded_ordered_list_engine boll_checker u_boll_checker (.*);
`default_nettype wire
